// ----- rtl/core/sesm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge sketch map package
// Shared sizes, register indexes, result constants and pipeline types.
// ----------------------------------------------------------------------------
package sesm_pkg;

   // Largest frame the row store and counters are sized for.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Fixed field widths.
   localparam int CFG_W      = 11;
   localparam int PIX_W      = 8;
   localparam int VAL_W      = 8;
   localparam int POS_W      = 10;
   localparam int RSP_PAD_W  = 4;
   localparam int RSP_DATA_W = VAL_W + 2 * POS_W + RSP_PAD_W;

   // Result queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Edge strength to sketch value mapping.
   localparam int               SUM_W         = 11;
   localparam logic [SUM_W-1:0] SKETCH_OFFSET = 11'd50;
   localparam logic [9:0]       RECIP3        = 10'd683;  // 2048/3 rounded up
   localparam int               RECIP_SHIFT   = 11;
   localparam logic [9:0]       SKETCH_RANGE  = 10'd100;
   localparam logic [VAL_W-1:0] SKETCH_BASE   = 8'd200;
   localparam logic [VAL_W-1:0] SKETCH_FLOOR  = 8'd100;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // One queued result.
   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic             last;
   } sesm_result_type;

   // What one pixel request produces: a first result (edge or border, or a
   // drained final-row pixel) and a second border result at the row end.
   typedef struct packed {
      logic             en0;
      logic             en1;
      logic             sobel;
      logic             last0;
      logic [POS_W-1:0] row0;
      logic [POS_W-1:0] col0;
      logic [POS_W-1:0] row1;
      logic [POS_W-1:0] col1;
   } sesm_meta_type;

endpackage

// ----- rtl/core/sobel_edge_sketch_map_unit.sv -----
// ----------------------------------------------------------------------------
// Sobel edge sketch map unit
// Streams gray pixels through a row store and a 3x3 window and emits one
// sketch value per pixel, in raster order, with its row and column.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the result queue has room and
// gives results at one per clock while rsp_tready is high; the last pixel of
// each row after row 0 produces two results, which the eight-entry result
// queue absorbs while the next row's first pixel produces none. The row store
// read and the Sobel sums for an accepted request are registered first, and
// the divide-by-three mapping follows as the result enters the queue.
// The result for pixel (r,c) is caused by the pixel
// (r+1,c+1), so results lag one row and one column; the final row of a frame
// is all border and drains during row 0 of the next frame, with rsp_tlast on
// its last column. Both row stores live in one 16-bit wide RAM; they are not
// cleared after reset, since unwritten entries never reach a result. A write
// to either size register restarts the frame; sizes saturate to 3..1024.
module sobel_edge_sketch_map_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sesm_pkg::PIX_W-1:0]       req_tdata,   // [7:0] gray_pixel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sesm_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] sketch_value,
                                                         // [17:8] out_row,
                                                         // [27:18] out_column
   output logic                             rsp_tlast,   // frame_last
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [sesm_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int COL_W = sesm_pkg::COL_W;
   localparam int ROW_W = sesm_pkg::ROW_W;
   localparam int PIX_W = sesm_pkg::PIX_W;
   localparam int POS_W = sesm_pkg::POS_W;
   localparam int VAL_W = sesm_pkg::VAL_W;
   localparam int SUM_W = sesm_pkg::SUM_W;
   localparam int PTR_W = sesm_pkg::FIFO_PTR_W;
   localparam int CNT_W = sesm_pkg::FIFO_CNT_W;

   function automatic int size_m1(input logic [sesm_pkg::CFG_W-1:0] v, input int hi);
      int n;
      n = int'(v);
      if (n < 3) begin
         return 2;
      end
      if (n > hi) begin
         return hi - 1;
      end
      return n - 1;
   endfunction

   // ------------------------------------------------------------------
   // Frame position and size registers
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in, wm1_ff, wm1_in;
   logic [ROW_W-1:0] row_ff, row_in, hm1_ff, hm1_in;
   logic             pend_ff, pend_in;
   logic             accept;
   logic             row_zero, at_end, pend_hit;
   sesm_pkg::sesm_meta_type meta0;

   assign accept   = req_tvalid & req_tready;
   assign row_zero = (row_ff == '0);
   assign at_end   = (col_ff == wm1_ff);
   assign pend_hit = row_zero & pend_ff;

   always_comb begin
      meta0.en0   = pend_hit | (!row_zero && col_ff != '0);
      meta0.en1   = !row_zero & at_end;
      meta0.sobel = !row_zero && row_ff >= ROW_W'(2) && col_ff >= COL_W'(2);
      meta0.last0 = pend_hit & at_end;
      meta0.row0  = row_zero ? POS_W'(hm1_ff) : POS_W'(row_ff - 1'b1);
      meta0.col0  = row_zero ? POS_W'(col_ff) : POS_W'(col_ff - 1'b1);
      meta0.row1  = POS_W'(row_ff - 1'b1);
      meta0.col1  = POS_W'(wm1_ff);
   end

   always_comb begin
      wm1_in  = wm1_ff;
      hm1_in  = hm1_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (csr_we) begin
         unique case (sesm_pkg::csr_index_type'(csr_addr))
            sesm_pkg::CSR_IMAGE_WIDTH: begin
               wm1_in = COL_W'(size_m1(csr_wdata, sesm_pkg::MAX_WIDTH));
            end
            sesm_pkg::CSR_IMAGE_HEIGHT: begin
               hm1_in = ROW_W'(size_m1(csr_wdata, sesm_pkg::MAX_HEIGHT));
            end
            default: begin
               wm1_in = wm1_ff;
            end
         endcase
         col_in  = '0;
         row_in  = '0;
         pend_in = 1'b0;
      end else if (accept) begin
         if (at_end) begin
            col_in = '0;
            if (row_ff == hm1_ff) begin
               row_in  = '0;
               pend_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
               if (pend_hit) begin
                  pend_in = 1'b0;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff  <= COL_W'(sesm_pkg::MAX_WIDTH - 1);
         hm1_ff  <= ROW_W'(sesm_pkg::MAX_HEIGHT - 1);
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         wm1_ff  <= wm1_in;
         hm1_ff  <= hm1_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: row store read data, window and Sobel sums
   // ------------------------------------------------------------------
   logic                    s1_valid_ff;
   sesm_pkg::sesm_meta_type s1_meta_ff;
   logic [PIX_W-1:0]        s1_px_ff;
   logic [COL_W-1:0]        s1_addr_ff;
   logic [2*PIX_W-1:0]      ram_rd_data;
   logic [PIX_W-1:0]        top, mid;
   logic [PIX_W-1:0]        win_ff [6];

   // Each entry holds {older row, newer row} for one column. Reads and the
   // write-back of one column never meet the same address in flight.
   sesm_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (sesm_pkg::MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   assign top = ram_rd_data[2*PIX_W-1:PIX_W];
   assign mid = ram_rd_data[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta0;
         s1_px_ff   <= req_tdata;
         s1_addr_ff <= col_ff;
      end
   end

   // Window columns: [0..2] left (top, middle, bottom), [3..5] center.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_px_ff;
      end
   end

   logic [9:0]       sx_pos, sx_neg, sy_pos, sy_neg, ax, ay;
   logic [SUM_W-1:0] sum_in;

   always_comb begin
      sx_pos = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, s1_px_ff};
      sx_neg = {2'b0, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b0, win_ff[2]};
      sy_pos = {2'b0, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b0, top};
      sy_neg = {2'b0, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b0, s1_px_ff};
      ax     = (sx_pos >= sx_neg) ? sx_pos - sx_neg : sx_neg - sx_pos;
      ay     = (sy_pos >= sy_neg) ? sy_pos - sy_neg : sy_neg - sy_pos;
      sum_in = {1'b0, ax} + {1'b0, ay};
   end

   // ------------------------------------------------------------------
   // Stage 2: (sum - 50) / 3 by reciprocal multiply, then the mapping
   // ------------------------------------------------------------------
   logic                    s2_valid_ff;
   sesm_pkg::sesm_meta_type s2_meta_ff;
   logic [SUM_W-1:0]        s2_sum_ff;
   logic [SUM_W-1:0]        excess;
   logic [SUM_W+9:0]        prod;
   logic [9:0]              quot;
   logic [VAL_W-1:0]        edge_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_meta_ff <= s1_meta_ff;
         s2_sum_ff  <= sum_in;
      end
   end

   // The reciprocal is exact for every excess the Sobel sums can reach.
   always_comb begin
      excess = s2_sum_ff - sesm_pkg::SKETCH_OFFSET;
      prod   = (SUM_W + 10)'(excess) * (SUM_W + 10)'(sesm_pkg::RECIP3);
      quot   = prod[SUM_W+9:sesm_pkg::RECIP_SHIFT];
      if (s2_sum_ff < sesm_pkg::SKETCH_OFFSET) begin
         edge_val = sesm_pkg::SKETCH_BASE;
      end else if (quot >= sesm_pkg::SKETCH_RANGE) begin
         edge_val = sesm_pkg::SKETCH_FLOOR;
      end else begin
         edge_val = sesm_pkg::SKETCH_BASE - quot[VAL_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   sesm_pkg::sesm_result_type fifo_ff [sesm_pkg::FIFO_DEPTH];
   sesm_pkg::sesm_result_type res0, res1, head;
   logic [PTR_W-1:0]          wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W:0]            need;
   logic                      push0, push1, pop;

   always_comb begin
      res0.value  = s2_meta_ff.sobel ? edge_val : sesm_pkg::SKETCH_BASE;
      res0.row    = s2_meta_ff.row0;
      res0.column = s2_meta_ff.col0;
      res0.last   = s2_meta_ff.last0;
      res1.value  = sesm_pkg::SKETCH_BASE;
      res1.row    = s2_meta_ff.row1;
      res1.column = s2_meta_ff.col1;
      res1.last   = 1'b0;
   end

   assign push0 = s2_valid_ff & s2_meta_ff.en0;
   assign push1 = s2_valid_ff & s2_meta_ff.en1;
   assign pop   = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wptr_ff] <= res0;
      end
      if (push1) begin
         fifo_ff[wptr_ff + PTR_W'(push0)] <= res1;
      end
   end

   always_comb begin
      wptr_in  = wptr_ff + PTR_W'(push0) + PTR_W'(push1);
      rptr_in  = rptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Each request in flight may still push two results; a new request is
   // taken only when the queue has room for all of them.
   assign need = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'({s1_valid_ff, 1'b0})
               + (CNT_W + 1)'({s2_valid_ff, 1'b0}) + (CNT_W + 1)'(2);
   assign req_tready = (need <= (CNT_W + 1)'(sesm_pkg::FIFO_DEPTH));

   assign head       = fifo_ff[rptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {{sesm_pkg::RSP_PAD_W{1'b0}}, head.column, head.row, head.value};
   assign rsp_tlast  = head.last;

endmodule

// ----- rtl/core/sesm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sesm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sesm_checker.sv -----
// ----------------------------------------------------------------------------
// Sobel edge sketch map port checker
// Watches the result channel of the unit and flags impossible results.
// ----------------------------------------------------------------------------
module sesm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sesm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);

   logic [sesm_pkg::VAL_W-1:0] rsp_value;
   logic [sesm_pkg::POS_W-1:0] rsp_column;

   assign rsp_value  = rsp_tdata[7:0];
   assign rsp_column = rsp_tdata[27:18];

   // No result can exist right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The mapping only produces values from 100 to 200.
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_value >= 8'd100 && rsp_value <= 8'd200)
      else $error("sketch value out of range");

   // The frame's last result is a border pixel in the last column.
   a_last_border: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_value == 8'd200 && rsp_column >= 10'd2)
      else $error("frame end result is not a border pixel");

endmodule

bind sobel_edge_sketch_map_unit sesm_checker u_sesm_checker (.*);

// ----- tb/sv/sobel_edge_sketch_map_unit_test.sv -----
// ----------------------------------------------------------------------------
// Sobel edge sketch map unit test
// Streams gray pixel frames of many sizes into the unit and checks every
// sketch result, with its row, column and frame-end flag, against a model of
// the row stores and the 3x3 window kept here. Both streams stall at random.
// ----------------------------------------------------------------------------
module sobel_edge_sketch_map_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_W      = sesm_pkg::PIX_W;
   localparam int VAL_W      = sesm_pkg::VAL_W;
   localparam int POS_W      = sesm_pkg::POS_W;
   localparam int CFG_W      = sesm_pkg::CFG_W;
   localparam int RSP_DATA_W = sesm_pkg::RSP_DATA_W;
   localparam int MAX_WIDTH  = sesm_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = sesm_pkg::MAX_HEIGHT;

   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int NO_EDGE        = 200;
   localparam int STRONGEST_EDGE = 100;
   localparam int EDGE_THRESHOLD = 50;
   localparam int RANDOM_PIXELS  = 168;
   localparam int CALM_PIXELS    = 128;

   typedef enum int {
      TEXTURE_NOISE,
      TEXTURE_FLAT,
      TEXTURE_BINARY,
      TEXTURE_RIPPLE
   } texture_kind_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PIX_W-1:0]        req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we     = 1'b0;
   sesm_pkg::csr_index_type csr_addr   = sesm_pkg::CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]        csr_wdata  = '0;

   // Bench copy of the unit's state.
   logic [PIX_W-1:0] upper_line [MAX_WIDTH];
   logic [PIX_W-1:0] middle_line [MAX_WIDTH];
   logic [PIX_W-1:0] window_taps [6];
   int unsigned      column_at;
   int unsigned      row_at;
   bit               final_row_owed;
   logic [CFG_W-1:0] width_setting;
   logic [CFG_W-1:0] height_setting;

   sesm_pkg::sesm_result_type sketch_expect [$];
   logic [PIX_W-1:0]          pending_pixels [$];

   bit idle_enable     = 1'b1;
   int send_gap        = 0;
   int hold_gap        = 0;
   int quiet_cycles    = 0;
   int mismatches      = 0;
   int results_checked = 0;
   int frame_ends      = 0;
   int pixels_taken    = 0;
   int size_writes     = 0;

   sobel_edge_sketch_map_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                             input int limit);
      if (raw < 3) return 3;
      if (raw > limit) return limit;
      return 32'(raw);
   endfunction

   function automatic void expect_sketch(input int value, input int unsigned row,
                                         input int unsigned column, input bit last);
      sesm_pkg::sesm_result_type res;
      res.value  = VAL_W'(value);
      res.row    = POS_W'(row);
      res.column = POS_W'(column);
      res.last   = last;
      sketch_expect.push_back(res);
   endfunction

   // Works out the results caused by one accepted pixel and advances the state.
   function automatic void predict_sketch(input logic [PIX_W-1:0] pixel);
      int unsigned w, h, c, r;
      logic [PIX_W-1:0] above, beside;
      int tl, ml, bl, tc, bc, tr, mr, br;
      int gx, gy, strength, level;
      w = clamp_dim(width_setting, MAX_WIDTH);
      h = clamp_dim(height_setting, MAX_HEIGHT);
      c = (column_at >= w) ? w - 1 : column_at;
      r = (row_at >= h) ? h - 1 : row_at;
      above  = upper_line[c];
      beside = middle_line[c];
      if (r == 0) begin
         // The previous frame's final row is all border and drains one per pixel.
         if (final_row_owed) begin
            expect_sketch(NO_EDGE, h - 1, c, c == w - 1);
            if (c == w - 1) final_row_owed = 1'b0;
         end
      end else begin
         if (c >= 1) begin
            level = NO_EDGE;
            if (r >= 2 && c >= 2) begin
               tl = int'(window_taps[0]);
               ml = int'(window_taps[1]);
               bl = int'(window_taps[2]);
               tc = int'(window_taps[3]);
               bc = int'(window_taps[5]);
               tr = int'(above);
               mr = int'(beside);
               br = int'(pixel);
               gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
               gy = (tl + 2 * tc + tr) - (bl + 2 * bc + br);
               strength = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
               level = 0;
               if (strength >= EDGE_THRESHOLD) begin
                  level = (strength - EDGE_THRESHOLD) / 3;
                  if (level > 255) level = 255;
               end
               level = NO_EDGE - level;
               if (level < STRONGEST_EDGE) level = STRONGEST_EDGE;
            end
            expect_sketch(level, r - 1, c - 1, 1'b0);
         end
         if (c == w - 1) expect_sketch(NO_EDGE, r - 1, w - 1, 1'b0);
      end
      window_taps[0] = window_taps[3];
      window_taps[1] = window_taps[4];
      window_taps[2] = window_taps[5];
      window_taps[3] = above;
      window_taps[4] = beside;
      window_taps[5] = pixel;
      upper_line[c]  = beside;
      middle_line[c] = pixel;
      if (c == w - 1) begin
         column_at = 0;
         if (r == h - 1) begin
            row_at = 0;
            final_row_owed = 1'b1;
         end else begin
            row_at = r + 1;
         end
      end else begin
         column_at = c + 1;
         row_at = r;
      end
   endfunction

   function automatic logic [PIX_W-1:0] next_pixel(input texture_kind_type texture,
                                                   input int base);
      int p;
      case (texture)
         TEXTURE_NOISE:  p = int'($urandom_range(0, 255));
         TEXTURE_FLAT:   p = base + int'($urandom_range(0, 12)) - 6;
         TEXTURE_BINARY: p = ($urandom_range(0, 1) != 0) ? 255 : 0;
         default:        p = base + int'($urandom_range(0, 60)) - 30;
      endcase
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      return PIX_W'(p);
   endfunction

   // Texture changes per row and the base level drifts slowly, so that flat
   // rows give edge strengths around the threshold.
   task automatic queue_pixels(input int row_len, input int count);
      texture_kind_type texture;
      int base;
      texture = TEXTURE_NOISE;
      base = int'($urandom_range(0, 255));
      for (int i = 0; i < count; i++) begin
         if (i % row_len == 0) begin
            texture = texture_kind_type'($urandom_range(0, 3));
            base = base + int'($urandom_range(0, 16)) - 8;
            if (base < 0) base = 0;
            if (base > 255) base = 255;
         end
         pending_pixels.push_back(next_pixel(texture, base));
      end
   endtask

   task automatic push_row(input int left, input int centre, input int right);
      pending_pixels.push_back(PIX_W'(left));
      pending_pixels.push_back(PIX_W'(centre));
      pending_pixels.push_back(PIX_W'(right));
   endtask

   // Holds off until every pixel is taken and every result has come back.
   task automatic settle_pipeline();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || sketch_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input sesm_pkg::csr_index_type index,
                             input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == sesm_pkg::CSR_IMAGE_WIDTH) width_setting = value;
      else height_setting = value;
      // Any size write restarts the frame and drops an owed final row.
      column_at = 0;
      row_at = 0;
      final_row_owed = 1'b0;
      size_writes++;
      @(negedge clock);
   endtask

   // Pixel driver; also feeds every accepted request to the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_sketch(req_tdata);
            pixels_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
               send_gap = int'($urandom_range(0, 18));
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pixels.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin : result_monitor
      sesm_pkg::sesm_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value  = rsp_tdata[VAL_W-1:0];
            got.row    = rsp_tdata[VAL_W+POS_W-1:VAL_W];
            got.column = rsp_tdata[VAL_W+2*POS_W-1:VAL_W+POS_W];
            got.last   = rsp_tlast;
            results_checked++;
            if (got.last === 1'b1) frame_ends++;
            if (sketch_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: value %0d row %0d column %0d last %b",
                           got.value, got.row, got.column, got.last);
            end else begin
               want = sketch_expect.pop_front();
               if (got.value !== want.value || got.row !== want.row ||
                   got.column !== want.column || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected value %0d row %0d column %0d last %b, %s",
                              want.value, want.row, want.column, want.last,
                              $sformatf("got value %0d row %0d column %0d last %b",
                                        got.value, got.row, got.column, got.last));
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            hold_gap = int'($urandom_range(0, 18));
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int random_pixels, count;
      int unsigned w, h;
      bit first_pass;
      logic [CFG_W-1:0] w_raw, h_raw;
      width_setting  = CFG_W'(MAX_WIDTH);
      height_setting = CFG_W'(MAX_HEIGHT);
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (window_taps[i]) window_taps[i] = '0;
      column_at = 0;
      row_at = 0;
      final_row_owed = 1'b0;
      random_pixels = 0;
      first_pass = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sizes below the floor saturate to a 3x3 frame.
      write_size(sesm_pkg::CSR_IMAGE_WIDTH, CFG_W'(2));
      write_size(sesm_pkg::CSR_IMAGE_HEIGHT, CFG_W'(0));
      // A bright top row over dark rows gives the strongest edge, which saturates.
      push_row(255, 255, 255);
      push_row(0, 0, 0);
      push_row(0, 0, 0);
      // A flat frame with a step in its corner lands just over the threshold;
      // its first row drains the final row of the frame before.
      push_row(10, 10, 10);
      push_row(10, 10, 10);
      push_row(10, 10, 37);
      settle_pipeline();
      // The write drops the owed final row, so the first row here gives nothing.
      write_size(sesm_pkg::CSR_IMAGE_HEIGHT, CFG_W'(3));
      push_row(0, 128, 255);
      push_row(255, 128, 0);
      settle_pipeline();

      while (random_pixels < RANDOM_PIXELS) begin
         w_raw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                             : CFG_W'($urandom_range(3, 8));
         if ($urandom_range(0, 9) == 0) h_raw = CFG_W'($urandom_range(MAX_HEIGHT + 1, 2047));
         else if ($urandom_range(0, 7) == 0) h_raw = CFG_W'($urandom_range(0, 2));
         else h_raw = CFG_W'($urandom_range(3, 8));
         idle_enable = (random_pixels < CALM_PIXELS) && ($urandom_range(0, 3) != 0);
         if (first_pass || $urandom_range(0, 3) != 0)
            write_size(sesm_pkg::CSR_IMAGE_WIDTH, w_raw);
         write_size(sesm_pkg::CSR_IMAGE_HEIGHT, h_raw);
         first_pass = 1'b0;
         w = clamp_dim(width_setting, MAX_WIDTH);
         h = clamp_dim(height_setting, MAX_HEIGHT);
         // Tall settings only get a few rows; small frames run whole, and a
         // part of the next frame drains the final row.
         if (h > 16) count = int'($urandom_range(2 * w, 5 * w));
         else count = int'($urandom_range(1, 2) * w * h + $urandom_range(0, w));
         if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
         queue_pixels(int'(w), count);
         random_pixels += count;
         settle_pipeline();
      end

      if (sketch_expect.size() != 0) begin
         $display("%0d expected results never arrived", sketch_expect.size());
         mismatches++;
      end
      $display("Covered %0d pixels over %0d size writes, small frames and saturated sizes.",
               pixels_taken, size_writes);
      $display("Checked %0d sketch results, %0d of them frame ends; %0d mismatches.",
               results_checked, frame_ends, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sesm_pkg.sv
rtl/core/sesm_ram.sv
rtl/core/sobel_edge_sketch_map_unit.sv
rtl/core/sesm_checker.sv
tb/sv/sobel_edge_sketch_map_unit_test.sv
